FILE: hdl/prm_pkg.sv
// ----------------------------------------------------------------------------
// prm_pkg
// Shared constants and types for the power rail monitor trip sequencer.
// ----------------------------------------------------------------------------
package prm_pkg;

  localparam int COMPONENTS_DEF = 16;
  localparam int SAMPLES_DEF    = 8;

  localparam logic [1:0] KIND_CONV  = 2'd0;
  localparam logic [1:0] KIND_VQRY  = 2'd1;
  localparam logic [1:0] KIND_CQRY  = 2'd2;
  localparam logic [1:0] KIND_SET   = 2'd3;

  localparam logic [1:0] SET_VUP    = 2'd0;
  localparam logic [1:0] SET_VLO    = 2'd1;
  localparam logic [1:0] SET_CUP    = 2'd2;
  localparam logic [1:0] SET_FLAGS  = 2'd3;

  localparam logic [1:0] PH_VOLT    = 2'd0;
  localparam logic [1:0] PH_CURR    = 2'd1;
  localparam logic [1:0] PH_TEMP    = 2'd2;
  localparam logic [1:0] PH_INIT    = 2'd3;

  localparam int FL_FORCE = 0;
  localparam int FL_TEMP  = 1;
  localparam int FL_SWON  = 2;

endpackage

FILE: hdl/power_rail_monitor_trip_sequencer_unit.sv
// Path: conversion, setting write and query with a pending critical value pass
//   ST_LOOK, ST_EXEC and ST_OUT to out_tvalid; a query with nothing pending also
//   passes ST_SUM (ring summed one entry a cycle through one adder) and ST_DIV.
// Flow: one item at a time, in_tready returns in ST_IDLE once the result loads;
//   a held result stalls ST_OUT.
// Reset (rst_n, sync, active low): ST_CLEAR zeroes ring, positions, flags, criticals.
// ----------------------------------------------------------------------------
// power_rail_monitor_trip_sequencer_unit
// Round-robin rail monitor: rings of samples, limit checks, trips, queries.
// ----------------------------------------------------------------------------
module power_rail_monitor_trip_sequencer_unit #(
  parameter int COMPONENTS = prm_pkg::COMPONENTS_DEF,
  parameter int SAMPLES    = prm_pkg::SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // sample[7:0], component[11:8], setting[13:12],
                                  // setting_value[21:14], zero pad
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // trip[0], tripped_component[4:1],
                                  // next_component[8:5], next_measure[10:9],
                                  // reported_value[18:11], reported_critical[19]
);
  import prm_pkg::*;

  localparam int CW  = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam int SW  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int RN  = COMPONENTS * 3;
  localparam int RW  = $clog2(RN);
  localparam int MD  = RN * SAMPLES;
  localparam int MW  = $clog2(MD);
  localparam int SUMW = 8 + SW + 1;
  // floor(sum / SAMPLES) as a reciprocal multiply, exact over the sum range
  localparam int DK  = SUMW + SW;
  localparam int DM  = ((1 << DK) + SAMPLES - 1) / SAMPLES;
  localparam int PW  = SUMW + DK + 1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_LOOK  = 7'b0000100,
    ST_EXEC  = 7'b0001000,
    ST_SUM   = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // per-component tables, each read at one address: the active or the latched query component
  logic [7:0] vup_r [COMPONENTS];
  logic [7:0] vlo_r [COMPONENTS];
  logic [7:0] cup_r [COMPONENTS];
  logic [2:0] flg_r [COMPONENTS];
  logic [7:0] vcrit_r [COMPONENTS];
  logic [7:0] ccrit_r [COMPONENTS];
  logic [SW-1:0] pos_r [RN];
  logic [7:0] ring_mem [MD];

  logic [1:0]    phase_r;
  logic [CW-1:0] cur_r;
  logic [1:0]    kind_r;
  logic [7:0]    samp_r, val_r;
  logic [5:0]    comp_r;
  logic [1:0]    set_r;
  logic          inrange_r;
  logic [MW:0]   clr_r;
  logic [SW:0]   cnt_r;
  logic [SUMW-1:0] sum_r;
  logic [7:0]    avg_r;
  logic [7:0]    rd_r;
  logic          rd_v_r;
  logic [23:0]   out_r;
  logic          ov_r;
  logic [RW-1:0] rbase_r;
  logic          trip_lat_r;

  // latched stage values
  logic [CW-1:0] c_r;
  logic [7:0] vup_q, vlo_q, cup_q, crit_q;
  logic [2:0] flg_q;
  logic [SW-1:0] pos_q;

  logic [CW-1:0] qc;
  logic          busy;
  logic [7:0]    rep;
  logic          repc;
  logic          trip;
  logic [MW-1:0] waddr;
  logic          we;
  logic [7:0]    wdata;
  logic [PW-1:0] avg_prod;

  assign qc = comp_r[CW-1:0];
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;
  assign avg_prod   = PW'(sum_r) * PW'(DM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
      phase_r <= PH_INIT;
      cur_r   <= '0;
    end else begin
      // output register reload in ST_OUT takes care of its own valid
      if (ov_r && out_tready && state_r != ST_OUT) ov_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          // one entry of each cleared table per cycle: positions, flags, criticals, ring
          clr_r <= clr_r + 1'b1;
          if (clr_r < (MW+1)'(RN)) pos_r[clr_r[RW-1:0]] <= '0;
          if (clr_r < (MW+1)'(COMPONENTS)) begin
            flg_r[clr_r[CW-1:0]]   <= '0;
            vcrit_r[clr_r[CW-1:0]] <= '0;
            ccrit_r[clr_r[CW-1:0]] <= '0;
          end
          if (clr_r == (MW+1)'(MD - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_tvalid) begin
            kind_r    <= in_tuser;
            samp_r    <= in_tdata[7:0];
            comp_r    <= {2'b00, in_tdata[11:8]};
            inrange_r <= ({3'b000, in_tdata[11:8]} < 7'(COMPONENTS));
            set_r     <= in_tdata[13:12];
            val_r     <= in_tdata[21:14];
            state_r   <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          // fetch table entries for the active component or the query target
          c_r <= (kind_r == KIND_CONV) ? cur_r : qc;
          if (kind_r == KIND_CONV) begin
            vup_q <= vup_r[cur_r];
            vlo_q <= vlo_r[cur_r];
            cup_q <= cup_r[cur_r];
            flg_q <= flg_r[cur_r];
            pos_q <= pos_r[RW'(cur_r * 3 + phase_r)];
            rbase_r <= RW'(cur_r * 3 + phase_r);
          end else begin
            crit_q <= (kind_r == KIND_VQRY) ? vcrit_r[qc] : ccrit_r[qc];
            rbase_r <= RW'(qc * 3 + ((kind_r == KIND_VQRY) ? 0 : 1));
          end
          cnt_r   <= '0;
          sum_r   <= '0;
          rd_v_r  <= 1'b0;
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          state_r <= ST_OUT;
          case (kind_r)
            KIND_CONV: begin
              if (phase_r == PH_INIT) phase_r <= PH_VOLT;
              else begin
                pos_r[rbase_r] <= (pos_q == SW'(SAMPLES - 1)) ? '0 : pos_q + 1'b1;
                if (trip) begin
                  flg_r[c_r][FL_SWON] <= 1'b0;
                  if (phase_r == PH_VOLT) vcrit_r[c_r] <= samp_r;
                  else ccrit_r[c_r] <= samp_r;
                end
                if (phase_r == PH_VOLT) phase_r <= PH_CURR;
                else if (phase_r == PH_CURR && flg_q[FL_TEMP]) phase_r <= PH_TEMP;
                else begin
                  phase_r <= PH_VOLT;
                  cur_r <= (cur_r == CW'(COMPONENTS - 1)) ? '0 : cur_r + 1'b1;
                end
              end
            end
            KIND_VQRY, KIND_CQRY: begin
              if (inrange_r && crit_q != 8'd0) begin
                if (kind_r == KIND_VQRY) vcrit_r[c_r] <= '0;
                else ccrit_r[c_r] <= '0;
              end else if (inrange_r) state_r <= ST_SUM;
            end
            default: begin
              if (inrange_r) begin
                case (set_r)
                  SET_VUP: vup_r[qc] <= val_r;
                  SET_VLO: vlo_r[qc] <= val_r;
                  SET_CUP: cup_r[qc] <= val_r;
                  default: flg_r[qc] <= val_r[2:0];
                endcase
              end
            end
          endcase
        end
        ST_SUM: begin
          // one memory read a cycle, accumulate the previous read
          if (rd_v_r) sum_r <= sum_r + SUMW'(rd_r);
          rd_v_r <= (cnt_r < (SW+1)'(SAMPLES));
          if (cnt_r < (SW+1)'(SAMPLES)) cnt_r <= cnt_r + 1'b1;
          else state_r <= ST_DIV;
        end
        ST_DIV: begin
          avg_r   <= avg_prod[DK +: 8];
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!ov_r || out_tready) begin
            out_r   <= {4'b0, repc, rep, (phase_r == PH_INIT) ? PH_VOLT : phase_r,
                        4'(cur_r), (trip_lat_r ? 4'(c_r) : 4'd0), trip_lat_r};
            ov_r    <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // trip latched for the output stage
  always_ff @(posedge clk) begin
    if (state_r == ST_LOOK) trip_lat_r <= 1'b0;
    else if (state_r == ST_EXEC) trip_lat_r <= trip;
  end

  always_comb begin
    trip = 1'b0;
    if (kind_r == KIND_CONV) begin
      if (phase_r == PH_VOLT)
        trip = (samp_r > vup_q && !flg_q[FL_FORCE]) || (samp_r < vlo_q && flg_q[FL_SWON]);
      else if (phase_r == PH_CURR)
        trip = samp_r > cup_q && !flg_q[FL_FORCE];
    end
  end

  always_comb begin
    rep  = 8'd0;
    repc = 1'b0;
    if ((kind_r == KIND_VQRY || kind_r == KIND_CQRY) && inrange_r) begin
      if (crit_q != 8'd0) begin
        rep = crit_q;
        repc = 1'b1;
      end else rep = avg_r;
    end
  end

  // ring memory: single write port, single registered read port
  always_comb begin
    busy  = (state_r == ST_CLEAR);
    we    = busy || (state_r == ST_EXEC && kind_r == KIND_CONV && phase_r != PH_INIT);
    waddr = busy ? clr_r[MW-1:0] : MW'(rbase_r * SAMPLES + pos_q);
    wdata = busy ? 8'd0 : samp_r;
  end

  always_ff @(posedge clk) begin
    if (we) ring_mem[waddr] <= wdata;
    rd_r <= ring_mem[MW'(rbase_r * SAMPLES + cnt_r[SW-1:0])];
  end

endmodule
